// ===== sv/aid_pkg.sv =====
package aid_pkg;

  localparam int AID_CAPACITY = 128;
  // Widths of the values broadcast down the chain; wide enough for the largest capacity
  localparam int AID_MAX_W = 11;
  localparam int AID_DATA_W = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_SEARCH = 1'b1
  } state_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic                    ins;
    logic                    del;
    logic                    cmp;
    logic [AID_MAX_W-1:0]    pos;
    logic [AID_MAX_W-1:0]    count;
    logic [AID_DATA_W-1:0]   value;
  } cell_cmd_t;

endpackage

// ===== sv/aid_cell.sv =====
module aid_cell
  import aid_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic                  clk,
  input  cell_cmd_t             cmd,
  input  logic [AID_DATA_W-1:0] left_data,
  input  logic [AID_DATA_W-1:0] right_data,
  output logic [AID_DATA_W-1:0] data,
  output logic                  match
);

  localparam logic [AID_MAX_W-1:0] MyIdx = AID_MAX_W'(IDX);

  logic [AID_DATA_W-1:0] data_next;

  always_comb begin
    data_next = data;
    if (cmd.ins && (MyIdx > cmd.pos)) begin
      data_next = left_data;
    end else if (cmd.ins && (MyIdx == cmd.pos)) begin
      data_next = cmd.value;
    end else if (cmd.del && (MyIdx >= cmd.pos)) begin
      data_next = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data  <= data_next;
    // only entries below the count take part in a search
    match <= cmd.cmp && (data == cmd.value) && (MyIdx < cmd.count);
  end

endmodule

// ===== sv/aid_ptree.sv =====
module aid_ptree
  import aid_pkg::*;
#(
  parameter int NLEAF = 128,
  parameter int IW    = 7
) (
  input  logic             clk,
  input  logic [NLEAF-1:0] hits,
  output logic             root_hit,
  output logic [IW-1:0]    root_idx
);

  // Heap layout: node 1 is the root, nodes NLEAF..2*NLEAF-1 are the leaves
  logic          hit_q [1:NLEAF-1];
  logic [IW-1:0] idx_q [1:NLEAF-1];
  logic          node_hit [1:2*NLEAF-1];
  logic [IW-1:0] node_idx [1:2*NLEAF-1];

  always_comb begin
    for (int k = 1; k < NLEAF; k++) begin
      node_hit[k] = hit_q[k];
      node_idx[k] = idx_q[k];
    end
    for (int j = 0; j < NLEAF; j++) begin
      node_hit[NLEAF+j] = hits[j];
      node_idx[NLEAF+j] = IW'(j);
    end
  end

  // One level of the tree per register stage; lower index wins
  always_ff @(posedge clk) begin
    for (int k = 1; k < NLEAF; k++) begin
      hit_q[k] <= node_hit[2*k] | node_hit[2*k+1];
      idx_q[k] <= node_hit[2*k] ? node_idx[2*k] : node_idx[2*k+1];
    end
  end

  assign root_hit = hit_q[1];
  assign root_idx = idx_q[1];

endmodule

// ===== sv/array_insert_delete_search.sv =====
// Ordered list of up to CAPACITY signed 32-bit entries held in a chain of cells, one entry per
// cell. A request is taken when start is high and busy is low. For insert, delete and an unused op
// the result strobes on done in the next cycle and a new request may follow at once. Search
// raises busy while the cells compare in a registered step, then while each level of the
// registered priority tree, one register stage per level, picks the lowest matching position.
// done is high for exactly one cycle per request and cannot be held off; capture the result
// then. Entries start undefined; only positions below the count are ever searched or reported.
module array_insert_delete_search
  import aid_pkg::*;
#(
  parameter int CAPACITY = AID_CAPACITY
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  op,
  input  logic [31:0] value,
  input  logic [6:0]  position,
  output logic        busy,
  output logic        done,
  output logic [1:0]  status,
  output logic [6:0]  found_position,
  output logic [7:0]  entry_count
);

  localparam int IW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int NLEAF = 1 << IW;
  localparam int WW    = $clog2(IW + 1);
  localparam logic [AID_MAX_W-1:0] CapW = AID_MAX_W'(CAPACITY);

  state_t         state, state_next;
  logic [CW-1:0]  count, count_next;
  logic [WW-1:0]  wait_cnt, wait_cnt_next;
  logic           done_next;
  status_t        status_q, status_next;
  logic [6:0]     found_position_next;

  logic           accept;
  logic           search_last;
  logic           is_full, ins_bad, del_bad;
  logic [AID_MAX_W-1:0] pos_w, count_w;
  cell_cmd_t      cmd;

  logic [AID_DATA_W-1:0] cell_data [0:CAPACITY-1];
  logic [NLEAF-1:0]      hits;
  logic                  root_hit;
  logic [IW-1:0]         root_idx;

  assign accept      = start && !busy;
  assign pos_w       = AID_MAX_W'(position);
  assign count_w     = AID_MAX_W'(count);
  assign is_full     = count_w >= CapW;
  assign ins_bad     = pos_w > count_w;
  assign del_bad     = pos_w >= count_w;
  assign search_last = (state == S_SEARCH) && (wait_cnt == WW'(IW));

  always_comb begin
    cmd.ins   = accept && (op_t'(op) == OP_INSERT) && !is_full && !ins_bad;
    cmd.del   = accept && (op_t'(op) == OP_DELETE) && !del_bad;
    cmd.cmp   = accept && (op_t'(op) == OP_SEARCH);
    cmd.pos   = pos_w;
    cmd.count = count_w;
    cmd.value = value;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.cmp) begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (search_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs and datapath control
  always_comb begin
    busy                = (state == S_SEARCH);
    wait_cnt_next       = (state == S_SEARCH) ? wait_cnt + WW'(1) : '0;
    count_next          = count;
    done_next           = 1'b0;
    status_next         = status_q;
    found_position_next = found_position;
    if (cmd.ins) begin
      count_next = count + CW'(1);
    end else if (cmd.del) begin
      count_next = count - CW'(1);
    end
    if (accept && (op_t'(op) != OP_SEARCH)) begin
      done_next           = 1'b1;
      found_position_next = '0;
      case (op_t'(op))
        OP_INSERT: status_next = is_full ? ST_FULL : (ins_bad ? ST_BADPOS : ST_OK);
        OP_DELETE: status_next = del_bad ? ST_BADPOS : ST_OK;
        default:   status_next = ST_OK;
      endcase
    end else if (search_last) begin
      done_next           = 1'b1;
      status_next         = root_hit ? ST_OK : ST_NOTFOUND;
      found_position_next = root_hit ? 7'(root_idx) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      wait_cnt <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      wait_cnt <= wait_cnt_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    status_q       <= status_next;
    found_position <= found_position_next;
  end

  assign status      = status_q;
  assign entry_count = 8'(count);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [AID_DATA_W-1:0] left_d, right_d;
    logic                  m;
    if (i == 0) begin : g_first
      assign left_d = cmd.value;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    aid_cell #(.IDX(i)) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .left_data (left_d),
      .right_data(right_d),
      .data      (cell_data[i]),
      .match     (m)
    );
    assign hits[i] = m;
  end

  for (genvar j = CAPACITY; j < NLEAF; j++) begin : g_pad
    assign hits[j] = 1'b0;
  end

  aid_ptree #(.NLEAF(NLEAF), .IW(IW)) u_ptree (
    .clk     (clk),
    .hits    (hits),
    .root_hit(root_hit),
    .root_idx(root_idx)
  );

endmodule

// ===== sv/aid_checker.sv =====
module aid_checker
  import aid_pkg::*;
#(
  parameter int CAPACITY = AID_CAPACITY
) (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic [1:0]  op,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic [6:0]  found_position,
  input logic [7:0]  entry_count
);

  localparam logic [7:0] CapCount = 8'(CAPACITY);

  // A taken request either answers next cycle or keeps the block busy
  a_req_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("request neither answered nor in progress");

  // A search ends with its result
  a_busy_ends_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result");

  // Only a successful search reports a position
  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status_t'(status) != ST_OK)) |-> (found_position == 7'd0))
    else $error("nonzero position on a failed request");

  // Full is reported only when the list holds CAPACITY entries
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && (status_t'(status) == ST_FULL)) |-> (entry_count == CapCount))
    else $error("full reported with wrong count");

  // Count changes only with a result
  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    !done |=> (done || $stable(entry_count)))
    else $error("count changed without a result");

endmodule

bind array_insert_delete_search aid_checker #(.CAPACITY(CAPACITY)) u_aid_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .op            (op),
  .busy          (busy),
  .done          (done),
  .status        (status),
  .found_position(found_position),
  .entry_count   (entry_count)
);
